// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is silent while reset is asserted.
`define RTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define RTT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/core/rtt_pkg.sv -----
// Types, codes and constants of the repeating timer table.
`timescale 1ns / 1ps
package rtt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = $clog2(NUM_SLOTS);

    // Command codes.
    localparam logic [2:0] FN_REGISTER   = 3'd0;
    localparam logic [2:0] FN_REMOVE_ID  = 3'd1;
    localparam logic [2:0] FN_REMOVE_OWN = 3'd2;
    localparam logic [2:0] FN_REMOVE_GLB = 3'd3;
    localparam logic [2:0] FN_TICK_GLB   = 3'd4;
    localparam logic [2:0] FN_TICK_OWN   = 3'd5;
    localparam logic [2:0] FN_CLEAR      = 3'd6;
    localparam logic [2:0] FN_COUNT      = 3'd7;

    // Status codes.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;

    localparam logic [1:0] KIND_GLOBAL = 2'd0;
    localparam logic [4:0] COUNT_MAX   = 5'd31;

    // One stored timer.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] owner;
        logic [1:0]  kind;
        logic [31:0] delay;
        logic [31:0] repeats;
        logic [31:0] remaining;
        logic [31:0] elapsed;
    } slot_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [31:0] result_id;
        logic [1:0]  result_kind;
        logic [31:0] result_delay;
        logic [31:0] result_repeats;
        logic [4:0]  count;
        logic        last;
    } res_t;

    // Push request from the sequencer to the output stage.
    typedef struct packed {
        logic valid;
        res_t data;
    } push_t;

endpackage

// ----- rtl/core/rtt_if.sv -----
// Command and result channel interfaces of the timer table.
`timescale 1ns / 1ps
interface rtt_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] event_id;
    logic [31:0] owner_tag;
    logic [1:0]  kind;
    logic [31:0] delay;
    logic [31:0] repeats;
    logic [31:0] elapsed_ms;

    modport source (output valid, func, event_id, owner_tag, kind, delay, repeats,
                    elapsed_ms, input ready);
    modport sink (input valid, func, event_id, owner_tag, kind, delay, repeats,
                  elapsed_ms, output ready);
endinterface

interface rtt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        fired;
    logic [31:0] result_id;
    logic [1:0]  result_kind;
    logic [31:0] result_delay;
    logic [31:0] result_repeats;
    logic [4:0]  count;
    logic        last;

    modport source (output valid, status, fired, result_id, result_kind, result_delay,
                    result_repeats, count, last, input ready);
    modport sink (input valid, status, fired, result_id, result_kind, result_delay,
                  result_repeats, count, last, output ready);
endinterface

// ----- rtl/core/rtt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- rtl/core/rtt_out.sv -----
// Output register that holds one result item for the receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtt_out (
    input  logic           clk,
    input  logic           rst_n,
    input  rtt_pkg::push_t push,
    output logic           can_push,
    rtt_res_if.source      res
);
    import rtt_pkg::*;

    logic valid_reg;
    res_t data_reg;

    // A new item may enter when the register is empty or being drained.
    assign can_push = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_push)
        begin
            valid_reg <= push.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_push && push.valid)
        begin
            data_reg <= push.data;
        end
    end

    assign res.valid          = valid_reg;
    assign res.status         = data_reg.status;
    assign res.fired          = data_reg.fired;
    assign res.result_id      = data_reg.result_id;
    assign res.result_kind    = data_reg.result_kind;
    assign res.result_delay   = data_reg.result_delay;
    assign res.result_repeats = data_reg.result_repeats;
    assign res.count          = data_reg.count;
    assign res.last           = data_reg.last;

    `RTT_ASSERT(a_no_push_when_full, !(push.valid && !can_push), "push into a full output register")
    `RTT_ASSERT_NEXT(a_stall_holds, valid_reg && !res.ready, valid_reg, "stalled item dropped")
endmodule

// ----- rtl/core/repeating_timer_table.sv -----
// Top level of the repeating timer table: command sequencer, slot RAM and output stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// Commands arrive on the cmd channel and results leave on the res channel; both
// move an item when valid and ready are high at a rising clock edge.
// Register goes from acceptance to the done state, which loads its one item into the
// output register once that has room. Every other command walks the slots of the
// slot RAM in order, visiting a free slot in the read state alone and a used one in
// the read state and then the process state (RAM read, then match test and, for a
// tick, write back), and loads its final item from the done state after the walk;
// remove id stops at the first matching slot. One command is handled at a time and
// cmd.ready is high only between commands, so it returns in the cycle after the
// final item is loaded.
// A tick sends one item per firing timer in slot order with last set on the
// final one, or a single item with fired low when nothing fires.
// A pending firing waits in the sequencer; when the receiver stalls, the walk
// stops at the next firing timer until room opens, and nothing is lost.
// Reset marks every slot free and sets the next id to one; no RAM clearing pass
// is needed since slot contents are read only while the slot is in use.
module repeating_timer_table (
    input  logic      clk,
    input  logic      rst_n,
    rtt_cmd_if.sink   cmd,
    rtt_res_if.source res
);
    import rtt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_PROC, S_DONE} state_t;

    state_t                 state_reg;
    logic [NUM_SLOTS-1:0]   valid_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [31:0]            next_id_reg;
    logic [2:0]             func_reg;
    logic [31:0]            eid_reg;
    logic [31:0]            owner_reg;
    logic [31:0]            dt_reg;
    logic [1:0]             sts_reg;
    logic [31:0]            rid_reg;
    logic [4:0]             cnt_reg;
    logic                   pend_valid_reg;
    res_t                   pend_reg;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    slot_t                  wr_slot;
    logic                   rd_en;
    slot_t                  rd_slot;
    push_t                  push;
    logic                   can_push;

    logic                   accept;
    logic                   full;
    logic [IDX_W-1:0]       free_idx;
    logic                   is_tick;
    logic                   hit;
    logic [32:0]            sum;
    logic [31:0]            e_new;
    logic                   fire;
    logic                   stall;
    logic                   at_end;
    logic                   retire;
    res_t                   fire_res;
    res_t                   final_res;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign at_end    = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign is_tick   = (func_reg == FN_TICK_GLB) || (func_reg == FN_TICK_OWN);

    // Lowest free slot.
    always_comb
    begin
        full     = 1'b1;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                full     = 1'b0;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Match test of the slot just read.
    always_comb
    begin
        case (func_reg)
            FN_REMOVE_ID:  hit = (rd_slot.id == eid_reg);
            FN_REMOVE_OWN,
            FN_COUNT,
            FN_TICK_OWN:   hit = (rd_slot.kind != KIND_GLOBAL) && (rd_slot.owner == owner_reg);
            FN_REMOVE_GLB,
            FN_TICK_GLB:   hit = (rd_slot.kind == KIND_GLOBAL);
            FN_CLEAR:      hit = 1'b1;
            default:       hit = 1'b0;
        endcase
    end

    // Saturating elapsed time and the firing test.
    assign sum    = {1'b0, rd_slot.elapsed} + {1'b0, dt_reg};
    assign e_new  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign fire   = is_tick && hit && (e_new >= rd_slot.delay);
    assign stall  = fire && pend_valid_reg && !can_push;
    assign retire = fire && (rd_slot.repeats != 32'd0) && (rd_slot.remaining <= 32'd1);

    always_comb
    begin
        fire_res                = '0;
        fire_res.fired          = 1'b1;
        fire_res.result_id      = rd_slot.id;
        fire_res.result_kind    = rd_slot.kind;
        fire_res.result_delay   = rd_slot.delay;
        fire_res.result_repeats = rd_slot.repeats;
    end

    // Final item of a command.
    always_comb
    begin
        final_res = '0;
        if (is_tick)
        begin
            if (pend_valid_reg)
            begin
                final_res = pend_reg;
            end
        end
        else
        begin
            final_res.status    = sts_reg;
            final_res.result_id = rid_reg;
            final_res.count     = cnt_reg;
        end
        final_res.last = 1'b1;
    end

    // Pushes toward the output register, only when it has room.
    always_comb
    begin
        push = '0;
        if (state_reg == S_DONE && can_push)
        begin
            push.valid = 1'b1;
            push.data  = final_res;
        end
        else if (state_reg == S_PROC && fire && pend_valid_reg && can_push)
        begin
            push.valid = 1'b1;
            push.data  = pend_reg;
        end
    end

    // RAM access: read in the walk, write on register or tick update.
    assign rd_en = (state_reg == S_READ) && valid_reg[idx_reg];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_slot = rd_slot;
        if (accept && cmd.func == FN_REGISTER && !full)
        begin
            wr_en             = 1'b1;
            wr_addr           = free_idx;
            wr_slot.id        = next_id_reg;
            wr_slot.owner     = cmd.owner_tag;
            wr_slot.kind      = cmd.kind;
            wr_slot.delay     = cmd.delay;
            wr_slot.repeats   = cmd.repeats;
            wr_slot.remaining = cmd.repeats;
            wr_slot.elapsed   = 32'd0;
        end
        else if (state_reg == S_PROC && is_tick && hit && !stall)
        begin
            wr_en = 1'b1;
            if (fire)
            begin
                wr_slot.elapsed = 32'd0;
                if (rd_slot.repeats != 32'd0)
                begin
                    wr_slot.remaining = retire ? 32'd0 : rd_slot.remaining - 32'd1;
                end
            end
            else
            begin
                wr_slot.elapsed = e_new;
            end
        end
    end

    rtt_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_slot)
    );

    rtt_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .can_push (can_push),
        .res      (res)
    );

    // Sequencer state and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            idx_reg        <= '0;
            next_id_reg    <= 32'd1;
            pend_valid_reg <= 1'b0;
            func_reg       <= FN_REGISTER;
            eid_reg        <= '0;
            owner_reg      <= '0;
            dt_reg         <= '0;
            sts_reg        <= STS_OK;
            rid_reg        <= '0;
            cnt_reg        <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg       <= cmd.func;
                        eid_reg        <= cmd.event_id;
                        owner_reg      <= cmd.owner_tag;
                        dt_reg         <= cmd.elapsed_ms;
                        idx_reg        <= '0;
                        cnt_reg        <= '0;
                        rid_reg        <= '0;
                        pend_valid_reg <= 1'b0;
                        sts_reg        <= (cmd.func == FN_REMOVE_ID) ? STS_NOT_FOUND : STS_OK;
                        if (cmd.func == FN_REGISTER)
                        begin
                            state_reg <= S_DONE;
                            if (full)
                            begin
                                sts_reg <= STS_FULL;
                            end
                            else
                            begin
                                valid_reg[free_idx] <= 1'b1;
                                rid_reg             <= next_id_reg;
                                next_id_reg         <= (next_id_reg == 32'hFFFF_FFFF) ?
                                                       32'd1 : next_id_reg + 32'd1;
                            end
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    if (valid_reg[idx_reg])
                    begin
                        state_reg <= S_PROC;
                    end
                    else if (at_end)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_PROC:
                begin
                    if (!stall)
                    begin
                        state_reg <= at_end ? S_DONE : S_READ;
                        idx_reg   <= idx_reg + IDX_W'(1);
                        if (is_tick)
                        begin
                            if (fire)
                            begin
                                pend_valid_reg <= 1'b1;
                                pend_reg       <= fire_res;
                            end
                            if (retire)
                            begin
                                valid_reg[idx_reg] <= 1'b0;
                            end
                        end
                        else if (hit)
                        begin
                            if (cnt_reg != COUNT_MAX)
                            begin
                                cnt_reg <= cnt_reg + 5'd1;
                            end
                            if (func_reg != FN_COUNT)
                            begin
                                valid_reg[idx_reg] <= 1'b0;
                            end
                            if (func_reg == FN_REMOVE_ID)
                            begin
                                sts_reg   <= STS_OK;
                                state_reg <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE:
                begin
                    if (can_push)
                    begin
                        state_reg <= S_IDLE;
                        if (func_reg == FN_CLEAR)
                        begin
                            next_id_reg <= 32'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `RTT_ASSERT(a_no_rw_overlap, !(wr_en && rd_en), "slot RAM read and written together")
    `RTT_ASSERT_NEXT(a_register_fills,
        accept && cmd.func == FN_REGISTER && !full,
        $countones(valid_reg) == $past($countones(valid_reg)) + 1,
        "register did not take a slot")
    `RTT_ASSERT(a_pend_only_tick, !(pend_valid_reg && state_reg != S_IDLE && !is_tick),
        "pending firing outside a tick")
    `RTT_ASSERT(a_next_id_nonzero, next_id_reg != 32'd0, "next id is zero")
endmodule
